@@ design/mrp_pkg.sv @@
// ----------------------------------------------------------------------------
// mrp_pkg
// Shared widths, register indexes and defaults for the multi-ring placement core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrp_pkg;

   localparam int MAX_SERVERS_DEF = 256;
   localparam int MAX_RINGS_DEF   = 16;
   localparam int MAX_REPLICAS    = 8;
   localparam int RESULT_LIMIT    = 8;
   localparam int REPLICA_CAP     = (MAX_REPLICAS < RESULT_LIMIT) ? MAX_REPLICAS : RESULT_LIMIT;

   localparam int ID_W            = 64;
   localparam int SRV_W           = 8;
   localparam int RSEL_IN_W       = 4;
   localparam int POS_IN_W        = 8;
   localparam int REPL_W          = 4;
   localparam int REPL_NUM_W      = 3;
   localparam int SERVER_COUNT_W  = 9;
   localparam int RING_COUNT_W    = 5;
   localparam int CSR_INDEX_W     = 4;
   localparam int CSR_DATA_W      = 9;
   localparam int ENTRY_W         = ID_W + SRV_W;

   // remainder unit: bits retired per cycle
   localparam int MOD_DIGIT       = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_SERVER_COUNT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_RING_COUNT   = CSR_INDEX_W'(1);

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

endpackage

`default_nettype wire

@@ design/mrp_ram.sv @@
// ----------------------------------------------------------------------------
// mrp_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                          wdata,
   input  wire logic                                      re,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ design/mrp_mod.sv @@
// ----------------------------------------------------------------------------
// mrp_mod
// Iterative 64-bit remainder by a narrow divisor, MOD_DIGIT bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrp_mod
   import mrp_pkg::*;
#(
   parameter int DIV_W = 5
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [ID_W-1:0]  dividend,
   input  wire logic [DIV_W-1:0] divisor,
   output logic                  done,
   output logic      [DIV_W-1:0] rem
);

   localparam int STEPS = ID_W / MOD_DIGIT;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic [ID_W-1:0]  dividend_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] rem_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff;
   logic             done_ff;

   always_comb begin
      logic [DIV_W:0] r;
      r = {1'b0, rem_ff};
      for (int i = 0; i < MOD_DIGIT; i++) begin
         r = {r[DIV_W-1:0], dividend_ff[ID_W-1-i]};
         if (r >= {1'b0, divisor}) begin
            r = r - {1'b0, divisor};
         end
      end
      rem_in = r[DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (run_ff) begin
         cnt_ff  <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dividend_ff <= dividend;
         rem_ff      <= '0;
      end else if (run_ff) begin
         dividend_ff <= dividend_ff << MOD_DIGIT;
         rem_ff      <= rem_in;
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

@@ design/multiring_replica_placement_core.sv @@
// ----------------------------------------------------------------------------
// multiring_replica_placement_core
// Consistent-hashing replica placement over several rings held in one RAM.
//
//   channel  dir  beat                               handshake
//   req_     in   table write or placement lookup    req_valid / req_ready
//   rsp_     out  one server per replica             rsp_valid / rsp_ready
//   csr_     in   register write (index, data)       csr_valid / csr_ready
//
// A table write leaves req_ready high. A lookup keeps req_ready low through the
// remainder unit, the binary-search steps (S <= floor(log2 n)+1, each a RAM read
// and a compare), closing the search and starting the walk, and one RAM read per
// replica. Lookups run one at a time; a zero-replica lookup is accepted as a
// no-op. Reset is synchronous; registers return to 1, table contents are
// undefined until written. A stalled rsp_ beat holds the replica walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multiring_replica_placement_core
   import mrp_pkg::*;
#(
   parameter int MAX_SERVERS = MAX_SERVERS_DEF,
   parameter int MAX_RINGS   = MAX_RINGS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_command,
   input  wire logic [RSEL_IN_W-1:0]   req_ring_select,
   input  wire logic [POS_IN_W-1:0]    req_entry_position,
   input  wire logic [ID_W-1:0]        req_entry_id,
   input  wire logic [SRV_W-1:0]       req_entry_server,
   input  wire logic [ID_W-1:0]        req_object_id,
   input  wire logic [REPL_W-1:0]      req_replica_count,

   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic      [SRV_W-1:0]       rsp_server_index,
   output logic      [REPL_NUM_W-1:0]  rsp_replica_number,
   output logic                        rsp_last,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int DEPTH  = MAX_RINGS * MAX_SERVERS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW     = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int RSW    = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
   localparam int NW     = ($clog2(MAX_SERVERS + 1) > SERVER_COUNT_W) ?
                           $clog2(MAX_SERVERS + 1) : SERVER_COUNT_W;
   localparam int RW     = ($clog2(MAX_RINGS + 1) > RING_COUNT_W) ?
                           $clog2(MAX_RINGS + 1) : RING_COUNT_W;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MOD  = 6'b000010,
      ST_SRCH = 6'b000100,
      ST_CMP  = 6'b001000,
      ST_WALK = 6'b010000,
      ST_WOUT = 6'b100000
   } state_type;

   state_type                  state_ff, state_in;
   logic [SERVER_COUNT_W-1:0]  server_count_ff;
   logic [RING_COUNT_W-1:0]    ring_count_ff;
   logic [ID_W-1:0]            obj_ff;
   logic [REPL_W-1:0]          want_ff;
   logic [NW-1:0]              n_ff;
   logic [RSW-1:0]             ring_ff, ring_in;
   logic [NW-1:0]              lo_ff, lo_in, hi_ff, hi_in;
   logic [PW-1:0]              mid_ff, mid_in;
   logic [PW-1:0]              cur_ff, cur_in;
   logic [REPL_W-1:0]          k_ff, k_in;
   logic                       rsp_valid_ff;
   logic [SRV_W-1:0]           rsp_server_ff;
   logic [REPL_NUM_W-1:0]      rsp_num_ff;
   logic                       rsp_last_ff;

   logic [NW-1:0]              sc_ext, used_n;
   logic [RW-1:0]              rc_ext, used_rings;
   logic [REPL_W-1:0]          want_req;
   logic                       req_fire, lookup_fire, write_fire, write_ok;
   logic                       mod_start, mod_done;
   logic [RW-1:0]              mod_rem;
   logic [AW-1:0]              row_base;
   logic                       ram_we, ram_re;
   logic [AW-1:0]              ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0]         ram_rdata;
   logic [ID_W-1:0]            rd_id;
   logic [SRV_W-1:0]           rd_server;
   logic [NW:0]                mid_sum;
   logic [NW-1:0]              cur_inc;
   logic [PW-1:0]              cur_next;
   logic                       out_free, out_load, is_last;

   // clamped registers
   assign sc_ext     = NW'(server_count_ff);
   assign used_n     = (sc_ext == '0) ? NW'(1) :
                       (sc_ext > NW'(MAX_SERVERS)) ? NW'(MAX_SERVERS) : sc_ext;
   assign rc_ext     = RW'(ring_count_ff);
   assign used_rings = (rc_ext == '0) ? RW'(1) :
                       (rc_ext > RW'(MAX_RINGS)) ? RW'(MAX_RINGS) : rc_ext;
   assign want_req   = (req_replica_count > REPL_W'(REPLICA_CAP)) ?
                       REPL_W'(REPLICA_CAP) : req_replica_count;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign lookup_fire = req_fire && (req_command == CMD_LOOKUP);
   assign write_fire  = req_fire && (req_command == CMD_WRITE);
   assign write_ok    = (32'(req_ring_select) < MAX_RINGS) &&
                        (32'(req_entry_position) < MAX_SERVERS);
   assign mod_start   = lookup_fire && (want_req != '0);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         server_count_ff <= SERVER_COUNT_W'(1);
         ring_count_ff   <= RING_COUNT_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SERVER_COUNT: server_count_ff <= csr_data[SERVER_COUNT_W-1:0];
            CSR_RING_COUNT:   ring_count_ff   <= csr_data[RING_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   mrp_mod #(
      .DIV_W (RW)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (req_object_id),
      .divisor  (used_rings),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   // table RAM, entry = {id, server}
   assign ram_we    = write_fire && write_ok;
   assign ram_waddr = AW'(req_ring_select) * AW'(MAX_SERVERS) + AW'(req_entry_position);

   mrp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ({req_entry_id, req_entry_server}),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_id     = ram_rdata[ENTRY_W-1:SRV_W];
   assign rd_server = ram_rdata[SRV_W-1:0];
   assign row_base  = AW'(ring_ff) * AW'(MAX_SERVERS);

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign cur_inc  = NW'(cur_ff) + NW'(1);
   assign cur_next = (cur_inc >= n_ff) ? '0 : PW'(cur_inc);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_last  = ((k_ff + REPL_W'(1)) == want_ff);
   assign out_load = (state_ff == ST_WOUT) && out_free;

   always_comb begin
      state_in  = state_ff;
      ring_in   = ring_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      cur_in    = cur_ff;
      k_in      = k_ff;
      ram_re    = 1'b0;
      ram_raddr = row_base + AW'(cur_ff);
      case (state_ff)
         ST_IDLE: begin
            if (mod_start) begin
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               ring_in  = mod_rem[RSW-1:0];
               lo_in    = '0;
               hi_in    = n_ff;
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               mid_in    = mid_sum[PW:1];
               ram_re    = 1'b1;
               ram_raddr = row_base + AW'(mid_sum[PW:1]);
               state_in  = ST_CMP;
            end else begin
               cur_in   = (lo_ff == '0) ? PW'(n_ff - NW'(1)) : PW'(lo_ff - NW'(1));
               k_in     = '0;
               state_in = ST_WALK;
            end
         end
         ST_CMP: begin
            if (rd_id <= obj_ff) begin
               lo_in = NW'(mid_ff) + NW'(1);
            end else begin
               hi_in = NW'(mid_ff);
            end
            state_in = ST_SRCH;
         end
         ST_WALK: begin
            ram_re   = 1'b1;
            state_in = ST_WOUT;
         end
         ST_WOUT: begin
            if (out_free) begin
               k_in   = k_ff + REPL_W'(1);
               cur_in = cur_next;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = row_base + AW'(cur_next);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (lookup_fire) begin
         obj_ff  <= req_object_id;
         want_ff <= want_req;
         n_ff    <= used_n;
      end
      ring_ff <= ring_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      cur_ff  <= cur_in;
      k_ff    <= k_in;
      if (out_load) begin
         rsp_server_ff <= rd_server;
         rsp_num_ff    <= k_ff[REPL_NUM_W-1:0];
         rsp_last_ff   <= is_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_server_index   = rsp_server_ff;
   assign rsp_replica_number = rsp_num_ff;
   assign rsp_last           = rsp_last_ff;

   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRCH || state_ff == ST_CMP) |-> (lo_ff <= hi_ff) && (hi_ff <= n_ff))
      else $error("search bounds out of order");

   a_walk_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WOUT) |-> (NW'(cur_ff) < n_ff) && (k_ff < want_ff))
      else $error("replica walk out of range");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE) && !ram_re)
      else $error("table write during lookup");

   a_ring_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD && mod_done) |-> (mod_rem < used_rings))
      else $error("ring remainder out of range");

endmodule

`default_nettype wire

@@ bench/multiring_replica_placement_checker.sv @@
// ----------------------------------------------------------------------------
// multiring_replica_placement_checker
// Watches the req_, rsp_ and csr_ channels of the placement core. It keeps its
// own copy of the ring table and the geometry registers, predicts the servers
// of every accepted lookup and compares each rsp_ beat with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multiring_replica_placement_checker
   import mrp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire logic                   req_command,
   input  wire logic [RSEL_IN_W-1:0]   req_ring_select,
   input  wire logic [POS_IN_W-1:0]    req_entry_position,
   input  wire logic [ID_W-1:0]        req_entry_id,
   input  wire logic [SRV_W-1:0]       req_entry_server,
   input  wire logic [ID_W-1:0]        req_object_id,
   input  wire logic [REPL_W-1:0]      req_replica_count,

   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire logic [SRV_W-1:0]       rsp_server_index,
   input  wire logic [REPL_NUM_W-1:0]  rsp_replica_number,
   input  wire logic                   rsp_last,

   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,

   output int                          mismatch_total,
   output int                          results_owed
);

   localparam int TABLE_DEPTH = MAX_RINGS_DEF * MAX_SERVERS_DEF;

   typedef struct packed {
      logic [SRV_W-1:0]      server;
      logic [REPL_NUM_W-1:0] replica;
      logic                  last;
   } placement_type;

   logic [ID_W-1:0]           node_id_copy  [TABLE_DEPTH];
   logic [SRV_W-1:0]          node_srv_copy [TABLE_DEPTH];
   logic [SERVER_COUNT_W-1:0] server_count_q;
   logic [RING_COUNT_W-1:0]   ring_count_q;
   placement_type             owed_placements[$];
   int                        reported;

   function automatic void place_replicas(input logic [ID_W-1:0]   object_id,
                                          input logic [REPL_W-1:0] wanted);
      int            n, rings, ring, base, lo, hi, mid, cur, count;
      placement_type beat;
      n = (server_count_q == 0) ? 1 :
          (server_count_q > MAX_SERVERS_DEF) ? MAX_SERVERS_DEF : int'(server_count_q);
      rings = (ring_count_q == 0) ? 1 :
              (ring_count_q > MAX_RINGS_DEF) ? MAX_RINGS_DEF : int'(ring_count_q);
      count = (wanted > REPLICA_CAP) ? REPLICA_CAP : int'(wanted);
      ring = int'(object_id % ID_W'(rings));
      base = ring * MAX_SERVERS_DEF;
      lo = 0;
      hi = n;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (node_id_copy[base + mid] <= object_id) begin
            lo = mid + 1;
         end else begin
            hi = mid;
         end
      end
      cur = (lo == 0) ? n - 1 : lo - 1;
      for (int k = 0; k < count; k++) begin
         beat.server  = node_srv_copy[base + cur];
         beat.replica = REPL_NUM_W'(k);
         beat.last    = (k + 1 == count);
         owed_placements.push_back(beat);
         cur = (cur + 1 >= n) ? 0 : cur + 1;
      end
   endfunction

   always @(posedge clock) begin
      placement_type due;
      if (reset) begin
         server_count_q = 1;
         ring_count_q   = 1;
         owed_placements.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_placements.size() == 0) begin
               mismatch_total++;
               if (reported < 10) begin
                  reported++;
                  $display("%0t: unexpected rsp beat: server %0d replica %0d last %0b",
                           $realtime, rsp_server_index, rsp_replica_number, rsp_last);
               end
            end else begin
               due = owed_placements.pop_front();
               if (due.server !== rsp_server_index || due.replica !== rsp_replica_number ||
                   due.last !== rsp_last) begin
                  mismatch_total++;
                  if (reported < 10) begin
                     reported++;
                     $display("%0t: rsp mismatch exp/got: srv %0d/%0d rep %0d/%0d last %0b/%0b",
                              $realtime, due.server, rsp_server_index, due.replica,
                              rsp_replica_number, due.last, rsp_last);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_command == CMD_WRITE) begin
               node_id_copy[req_ring_select * MAX_SERVERS_DEF + req_entry_position]  =
                  req_entry_id;
               node_srv_copy[req_ring_select * MAX_SERVERS_DEF + req_entry_position] =
                  req_entry_server;
            end else begin
               place_replicas(req_object_id, req_replica_count);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SERVER_COUNT: server_count_q = csr_data[SERVER_COUNT_W-1:0];
               CSR_RING_COUNT:   ring_count_q   = csr_data[RING_COUNT_W-1:0];
               default: ;
            endcase
         end
      end
      results_owed = owed_placements.size();
   end

endmodule

@@ bench/tb_multiring_replica_placement_core.sv @@
// ----------------------------------------------------------------------------
// tb_multiring_replica_placement_core
// Drives table loads, lookups and geometry changes into the placement core
// through a directed opening and a series of preset geometries, with random
// gaps and rsp_ stalls; the checker beside the core scores every beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multiring_replica_placement_core;
   import mrp_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = '1;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 300;
   localparam int ROUNDS        = 5;
   localparam int ROUND_ITEMS   = 8;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_command;
   logic [RSEL_IN_W-1:0]   req_ring_select;
   logic [POS_IN_W-1:0]    req_entry_position;
   logic [ID_W-1:0]        req_entry_id;
   logic [SRV_W-1:0]       req_entry_server;
   logic [ID_W-1:0]        req_object_id;
   logic [REPL_W-1:0]      req_replica_count;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [SRV_W-1:0]       rsp_server_index;
   logic [REPL_NUM_W-1:0]  rsp_replica_number;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int  mismatch_total;
   int  results_owed;
   bit  calm;
   bit  hold_rsp;
   int  n_used;
   int  rings_used;
   logic [ID_W-1:0] id_mirror [MAX_RINGS_DEF * MAX_SERVERS_DEF];

   int round_servers [ROUNDS] = '{5, 1, 0, 3, 2};
   int round_rings   [ROUNDS] = '{1, 20, 0, 2, 5};

   multiring_replica_placement_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_ring_select    (req_ring_select),
      .req_entry_position (req_entry_position),
      .req_entry_id       (req_entry_id),
      .req_entry_server   (req_entry_server),
      .req_object_id      (req_object_id),
      .req_replica_count  (req_replica_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_server_index   (rsp_server_index),
      .rsp_replica_number (rsp_replica_number),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   multiring_replica_placement_checker placement_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_ring_select    (req_ring_select),
      .req_entry_position (req_entry_position),
      .req_entry_id       (req_entry_id),
      .req_entry_server   (req_entry_server),
      .req_object_id      (req_object_id),
      .req_replica_count  (req_replica_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_server_index   (rsp_server_index),
      .rsp_replica_number (rsp_replica_number),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatch_total     (mismatch_total),
      .results_owed       (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [ID_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // called at a falling edge; leaves valid high after the beat is taken
   task automatic push_item(input logic                 cmd,
                            input logic [RSEL_IN_W-1:0] ring,
                            input logic [POS_IN_W-1:0]  pos,
                            input logic [ID_W-1:0]      id,
                            input logic [SRV_W-1:0]     srv,
                            input logic [ID_W-1:0]      obj,
                            input logic [REPL_W-1:0]    reps);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_ring_select    <= ring;
      req_entry_position <= pos;
      req_entry_id       <= id;
      req_entry_server   <= srv;
      req_object_id      <= obj;
      req_replica_count  <= reps;
      if (cmd == CMD_WRITE) begin
         id_mirror[ring * MAX_SERVERS_DEF + pos] = id;
      end
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_entry(input int ring, input int pos, input logic [ID_W-1:0] id,
                              input logic [SRV_W-1:0] srv);
      push_item(CMD_WRITE, RSEL_IN_W'(ring), POS_IN_W'(pos), id, srv, rand64(),
                REPL_W'($urandom_range(0, 15)));
   endtask

   task automatic lookup(input logic [ID_W-1:0] obj, input logic [REPL_W-1:0] reps);
      push_item(CMD_LOOKUP, RSEL_IN_W'($urandom_range(0, 15)),
                POS_IN_W'($urandom_range(0, 255)), rand64(),
                SRV_W'($urandom_range(0, 255)), obj, reps);
   endtask

   task automatic set_reg(input logic [CSR_INDEX_W-1:0] index, input int data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= CSR_DATA_W'(data);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_geometry(input int servers, input int rings);
      set_reg(CSR_SERVER_COUNT, servers);
      set_reg(CSR_RING_COUNT, rings);
      n_used = (servers == 0) ? 1 : (servers > MAX_SERVERS_DEF) ? MAX_SERVERS_DEF : servers;
      rings = rings % 32;
      rings_used = (rings == 0) ? 1 : (rings > MAX_RINGS_DEF) ? MAX_RINGS_DEF : rings;
   endtask

   // drain: nothing owed, then room for a write or empty lookup still in flight
   task automatic settle();
      req_valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // non-decreasing IDs per ring, each congruent to its ring so exact hits are reachable
   task automatic fill_table();
      logic [ID_W-1:0] walk, step, id;
      int shift;
      shift = 2 + $clog2(n_used + 1);
      for (int r = 0; r < rings_used; r++) begin
         walk = rand64() >> 2;
         for (int p = 0; p < n_used; p++) begin
            step = ($urandom_range(0, 9) == 0) ? '0 : rand64() >> shift;
            walk = walk + step;
            id = walk - (walk % ID_W'(rings_used)) + ID_W'(r);
            write_entry(r, p, id, SRV_W'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic random_lookup();
      logic [ID_W-1:0]   anchor, obj;
      logic [REPL_W-1:0] reps;
      int r;
      r = $urandom_range(0, rings_used - 1);
      anchor = id_mirror[r * MAX_SERVERS_DEF + $urandom_range(0, n_used - 1)];
      case ($urandom_range(0, 6))
         0: obj = anchor;
         1: obj = anchor - ID_W'(rings_used);
         2: obj = anchor + ID_W'(rings_used);
         3: obj = rand64();
         4: obj = ID_W'($urandom_range(0, 63));
         5: obj = '1;
         default: obj = anchor + ID_W'($urandom_range(0, 1023) * rings_used);
      endcase
      if ($urandom_range(0, 9) == 0) begin
         reps = REPL_W'($urandom_range(0, 15));
      end else begin
         reps = REPL_W'($urandom_range(1, REPLICA_CAP));
      end
      lookup(obj, reps);
   endtask

   // result side: random stall bursts, a long hold on request
   initial begin
      rsp_ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            if (!calm) begin
               repeat ($urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 15)) @(negedge clock);
            end
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_command        = CMD_WRITE;
      req_ring_select    = '0;
      req_entry_position = '0;
      req_entry_id       = '0;
      req_entry_server   = '0;
      req_object_id      = '0;
      req_replica_count  = '0;
      csr_valid          = 1'b0;
      csr_index          = CSR_SERVER_COUNT;
      csr_data           = '0;
      calm               = 1'b0;
      hold_rsp           = 1'b0;
      n_used             = 1;
      rings_used         = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset geometry: one ring of one server
      write_entry(0, 0, '1, 8'hFF);
      write_entry(15, 255, '0, 8'h5A);
      lookup('0, 4'd1);
      lookup('1, 4'd0);
      lookup('1, 4'(REPLICA_CAP));
      lookup(64'd5, 4'hF);
      settle();

      // two rings of four, with a repeated ID, then one entry knocked out of order
      set_geometry(4, 2);
      write_entry(0, 0, 64'd10, 8'd1);
      write_entry(0, 1, 64'd20, 8'd2);
      write_entry(0, 2, 64'd20, 8'd3);
      write_entry(0, 3, 64'd30, 8'd4);
      write_entry(1, 0, 64'd11, 8'd5);
      write_entry(1, 1, 64'd21, 8'd6);
      write_entry(1, 2, 64'd41, 8'd7);
      write_entry(1, 3, 64'd61, 8'd8);
      lookup(64'd20, 4'd3);
      lookup(64'd8, 4'd2);
      lookup(64'd30, 4'd5);
      lookup(64'd61, 4'd1);
      lookup(64'd13, 4'd4);
      write_entry(0, 1, 64'd100, 8'd9);
      lookup(64'd24, 4'd2);

      for (int round = 0; round < ROUNDS; round++) begin
         settle();
         if (round == ROUNDS - 1) calm = 1'b1;
         set_geometry(round_servers[round], round_rings[round]);
         if (round == 2) set_reg(CSR_SPARE, 511);
         fill_table();
         if (round == 0) hold_rsp = 1'b1;
         for (int i = 0; i < ROUND_ITEMS; i++) begin
            if ($urandom_range(0, 4) == 0) begin
               if ($urandom_range(0, 1) == 0) begin
                  write_entry($urandom_range(0, 15), $urandom_range(0, 255), rand64(),
                              SRV_W'($urandom_range(0, 255)));
               end else begin
                  write_entry($urandom_range(0, rings_used - 1), $urandom_range(0, n_used - 1),
                              rand64(), SRV_W'($urandom_range(0, 255)));
               end
            end else begin
               random_lookup();
            end
         end
      end
      settle();

      if (mismatch_total == 0 && results_owed == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/mrp_pkg.sv
design/mrp_ram.sv
design/mrp_mod.sv
design/multiring_replica_placement_core.sv
bench/multiring_replica_placement_checker.sv
bench/tb_multiring_replica_placement_core.sv
